// ===== src/strm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the smoothed transfer rate meter: field widths, register
// indexes, divider command and result structs, and small helpers.
// No dependencies; every module of the block imports it.
package strm_pkg;

   // Field widths.
   localparam int BYTES_W = 48;
   localparam int MS_W    = 40;
   localparam int RATE_W  = 31;
   localparam int PCT_W   = 14;

   // Shared divider operand widths. The widest dividend is the
   // downloaded count scaled to hundredths of a percent.
   localparam int NUM_W = 62;
   localparam int DEN_W = 48;

   localparam int RING_DEPTH_DEF = 16;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PREV_BYTES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BYTES = 2'd1;

   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   // A zero rate is stored only on every third zero sample.
   localparam int ZERO_RUN = 3;

   // Two percent, in hundredths of a percent.
   localparam logic [PCT_W-1:0] PLAY_PCT = 14'd200;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quot;
      logic [DEN_W-1:0] rem;
   } div_res_type;

   // Index width for a ring of the given depth (at least one bit).
   function automatic int idx_w(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== src/strm_divider.sv =====
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on strm_pkg for operand widths and the command/result structs.
module strm_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  strm_pkg::div_cmd_type div_cmd,
   output strm_pkg::div_res_type div_res
);
   import strm_pkg::*;

   localparam int STEP_W = $clog2(NUM_W);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0]    shifted;
   logic [DEN_W+1:0]  trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (div_cmd.start) begin
         quo_in  = div_cmd.numer;
         rem_in  = '0;
         den_in  = div_cmd.denom;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Remainder stays below the divisor, so it fits DEN_W bits
         // whether or not the trial subtraction succeeds.
         if (!trial[DEN_W+1]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign div_res.busy = busy_ff;
   assign div_res.done = done_ff;
   assign div_res.quot = quo_ff;
   assign div_res.rem  = rem_ff;

endmodule

// ===== src/strm_ring.sv =====
`timescale 1ns / 1ps
// Ring of rate slots: one write port, one registered read port, and a
// valid bit per slot so that slots never written read as zero.
// Depends on strm_pkg for the rate width and the index width helper.
module strm_ring #(
   parameter int DEPTH = strm_pkg::RING_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [strm_pkg::idx_w(DEPTH)-1:0]      wr_idx,
   input  logic [strm_pkg::RATE_W-1:0]            wr_data,
   input  logic [strm_pkg::idx_w(DEPTH)-1:0]      rd_idx,
   output logic [strm_pkg::RATE_W-1:0]            rd_data
);
   import strm_pkg::*;

   logic [RATE_W-1:0] slot_mem [DEPTH];
   logic [DEPTH-1:0]  slot_vld_ff;
   logic [RATE_W-1:0] rd_word_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_word_ff <= slot_mem[rd_idx];
      rd_vld_ff  <= slot_vld_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
      end else if (wr_en) begin
         slot_vld_ff[wr_idx] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

endmodule

// ===== src/smoothed_transfer_rate_meter.sv =====
`timescale 1ns / 1ps
// Smoothed transfer rate meter. One sample in, one result beat out.
// Each sample runs up to four shared-divider divisions and a ring sweep that reads one slot per
// cycle. Only one sample is in flight: req_stall holds off a new sample until the result has
// been handed to the output register.
// Reset (synchronous): clears sample history, counters, the play flag, the
// configuration registers and the per-slot valid bits; no clearing pass.
module smoothed_transfer_rate_meter #(
   parameter int RING_DEPTH = strm_pkg::RING_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [strm_pkg::BYTES_W-1:0]      req_received_bytes,
   input  logic [strm_pkg::MS_W-1:0]         req_elapsed_ms,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [strm_pkg::BYTES_W-1:0]      rsp_downloaded_bytes,
   output logic [strm_pkg::RATE_W-1:0]       rsp_smoothed_rate,
   output logic                              rsp_progress_valid,
   output logic [strm_pkg::PCT_W-1:0]        rsp_percent_hundredths,
   output logic                              rsp_time_left_valid,
   output logic [strm_pkg::RATE_W-1:0]       rsp_seconds_left,
   output logic                              rsp_play_ready,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [strm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [strm_pkg::BYTES_W-1:0]      csr_wdata
);
   import strm_pkg::*;

   localparam int IDX_W = idx_w(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = RATE_W + CNT_W;
   localparam int RT_W  = BYTES_W + 5;

   // The sequencer walks each sample through its steps. The GO states
   // issue a command to the shared divider and the WAIT states hold until
   // its done pulse.
   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_SCALE,
      S_RATE_GO,
      S_RATE_WAIT,
      S_RING,
      S_SUM,
      S_SUM_END,
      S_AVG_GO,
      S_AVG_WAIT,
      S_PCT_GO,
      S_PCT_WAIT,
      S_SECS_GO,
      S_SECS_WAIT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [BYTES_W-1:0] prev_ff, prev_in;
   logic [BYTES_W-1:0] total_ff, total_in;

   // History and ring bookkeeping.
   logic [BYTES_W-1:0] last_rcvd_ff, last_rcvd_in;
   logic [MS_W-1:0]    last_time_ff, last_time_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [1:0]         zero_ticks_ff, zero_ticks_in;
   logic               play_ff, play_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Working registers for the sample in flight.
   logic [BYTES_W-1:0] rcvd_ff, rcvd_in;
   logic [MS_W-1:0]    now_ff, now_in;
   logic               pos_ff, pos_in;
   logic [BYTES_W-1:0] diff_b_ff, diff_b_in;
   logic [MS_W-1:0]    diff_t_ff, diff_t_in;
   logic [BYTES_W-1:0] dl_ff, dl_in;
   logic [RT_W-1:0]    rate_t_ff, rate_t_in;
   logic [NUM_W-1:0]   pct_a_ff, pct_a_in;
   logic [NUM_W-1:0]   pct_b_ff, pct_b_in;
   logic               pvalid_ff, pvalid_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [IDX_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [RATE_W-1:0]  smooth_ff, smooth_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic               tvalid_ff, tvalid_in;
   logic [RATE_W-1:0]  secs_ff, secs_in;

   // Result beat register.
   logic [BYTES_W-1:0] rsp_dl_ff, rsp_dl_in;
   logic [RATE_W-1:0]  rsp_rate_ff, rsp_rate_in;
   logic               rsp_pvalid_ff, rsp_pvalid_in;
   logic [PCT_W-1:0]   rsp_pct_ff, rsp_pct_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RATE_W-1:0]  rsp_secs_ff, rsp_secs_in;
   logic               rsp_play_ff, rsp_play_in;

   logic [BYTES_W:0]   dl_sum;
   logic               ring_wr_en;
   logic [RATE_W-1:0]  ring_rd_data;
   div_cmd_type        div_cmd;
   div_res_type        div_res;

   // Clamp a quotient to the 31-bit result range.
   function automatic logic [RATE_W-1:0] sat_rate(input logic [NUM_W-1:0] q);
      logic over;
      over = |q[NUM_W-1:RATE_W];
      return over ? RATE_MAX : q[RATE_W-1:0];
   endfunction

   strm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_res (div_res)
   );

   strm_ring #(
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr_en),
      .wr_idx  (wr_idx_ff),
      .wr_data (rate_ff),
      .rd_idx  (rd_cnt_ff),
      .rd_data (ring_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      total_in      = total_ff;
      last_rcvd_in  = last_rcvd_ff;
      last_time_in  = last_time_ff;
      wr_idx_in     = wr_idx_ff;
      fill_in       = fill_ff;
      zero_ticks_in = zero_ticks_ff;
      play_in       = play_ff;
      rd_pend_in    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      rcvd_in   = rcvd_ff;
      now_in    = now_ff;
      pos_in    = pos_ff;
      diff_b_in = diff_b_ff;
      diff_t_in = diff_t_ff;
      dl_in     = dl_ff;
      rate_t_in = rate_t_ff;
      pct_a_in  = pct_a_ff;
      pct_b_in  = pct_b_ff;
      pvalid_in = pvalid_ff;
      rate_in   = rate_ff;
      rd_cnt_in = rd_cnt_ff;
      sum_in    = sum_ff;
      smooth_in = smooth_ff;
      pct_in    = pct_ff;
      tvalid_in = tvalid_ff;
      secs_in   = secs_ff;

      rsp_dl_in     = rsp_dl_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_pvalid_in = rsp_pvalid_ff;
      rsp_pct_in    = rsp_pct_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_secs_in   = rsp_secs_ff;
      rsp_play_in   = rsp_play_ff;

      ring_wr_en    = 1'b0;
      div_cmd       = '0;
      dl_sum        = {1'b0, prev_ff} + {1'b0, rcvd_ff};

      // Configuration writes. Writes to unknown indexes are dropped.
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PREV_BYTES:  prev_in  = csr_wdata;
            CSR_TOTAL_BYTES: total_in = csr_wdata;
            default: ;
         endcase
      end

      // A ring read issued last cycle returns its slot now.
      if (rd_pend_ff) begin
         sum_in = sum_ff + SUM_W'(ring_rd_data);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rcvd_in  = req_received_bytes;
               now_in   = req_elapsed_ms;
               state_in = S_PREP;
            end
         end

         // Differences against the previous sample, the saturated
         // downloaded total, and a clean slate for per-sample results.
         S_PREP: begin
            pos_in       = (rcvd_ff > last_rcvd_ff) && (now_ff > last_time_ff);
            diff_b_in    = rcvd_ff - last_rcvd_ff;
            diff_t_in    = now_ff - last_time_ff;
            dl_in        = dl_sum[BYTES_W] ? {BYTES_W{1'b1}} : dl_sum[BYTES_W-1:0];
            last_rcvd_in = rcvd_ff;
            last_time_in = now_ff;
            rate_in      = '0;
            pct_in       = '0;
            tvalid_in    = 1'b0;
            secs_in      = '0;
            state_in     = S_SCALE;
         end

         // Constant products are built from shifts. Times 1000 is
         // 1024x - 24x; times 10000 is 10240x - 240x.
         S_SCALE: begin
            rate_t_in = (RT_W'(diff_b_ff) << 4) + (RT_W'(diff_b_ff) << 3);
            pct_a_in  = (NUM_W'(dl_ff) << 13) + (NUM_W'(dl_ff) << 11);
            pct_b_in  = (NUM_W'(dl_ff) << 8) - (NUM_W'(dl_ff) << 4);
            pvalid_in = (total_ff != '0) && (dl_ff <= total_ff);
            state_in  = pos_ff ? S_RATE_GO : S_RING;
         end

         S_RATE_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.numer = (NUM_W'(diff_b_ff) << 10) - NUM_W'(rate_t_ff);
            div_cmd.denom = DEN_W'(diff_t_ff);
            state_in      = S_RATE_WAIT;
         end

         S_RATE_WAIT: begin
            if (div_res.done) begin
               rate_in  = sat_rate(div_res.quot);
               state_in = S_RING;
            end
         end

         // A nonzero rate always lands in the ring; zero rates only on
         // every third zero sample. The fill count grows every sample until it reaches the ring depth.
         S_RING: begin
            if (rate_ff != '0) begin
               ring_wr_en = 1'b1;
            end else if (zero_ticks_ff == 2'(ZERO_RUN - 1)) begin
               ring_wr_en    = 1'b1;
               zero_ticks_in = '0;
            end else begin
               zero_ticks_in = zero_ticks_ff + 1'b1;
            end
            if (ring_wr_en) begin
               wr_idx_in = (wr_idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0
                         : wr_idx_ff + 1'b1;
            end
            if (fill_ff != CNT_W'(RING_DEPTH)) begin
               fill_in = fill_ff + 1'b1;
            end
            sum_in    = '0;
            rd_cnt_in = '0;
            state_in  = S_SUM;
         end

         // Sweep slots 0 .. fill-1, one read per cycle.
         S_SUM: begin
            rd_pend_in = 1'b1;
            if (CNT_W'(rd_cnt_ff) == fill_ff - 1'b1) begin
               state_in = S_SUM_END;
            end else begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
         end

         S_SUM_END: begin
            state_in = S_AVG_GO;
         end

         S_AVG_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.numer = NUM_W'(sum_ff);
            div_cmd.denom = DEN_W'(fill_ff);
            state_in      = S_AVG_WAIT;
         end

         S_AVG_WAIT: begin
            if (div_res.done) begin
               smooth_in = div_res.quot[RATE_W-1:0];
               state_in  = pvalid_ff ? S_PCT_GO : S_DONE;
            end
         end

         S_PCT_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.numer = pct_a_ff - pct_b_ff;
            div_cmd.denom = total_ff;
            state_in      = S_PCT_WAIT;
         end

         // Past two percent exactly when the quotient is above 200, or
         // equal to it with a nonzero remainder.
         S_PCT_WAIT: begin
            if (div_res.done) begin
               pct_in = div_res.quot[PCT_W-1:0];
               if ((div_res.quot[PCT_W-1:0] > PLAY_PCT) ||
                   ((div_res.quot[PCT_W-1:0] == PLAY_PCT) && (div_res.rem != '0))) begin
                  play_in = 1'b1;
               end
               state_in = (smooth_ff != '0) ? S_SECS_GO : S_DONE;
            end
         end

         S_SECS_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.numer = NUM_W'(total_ff - dl_ff);
            div_cmd.denom = DEN_W'(smooth_ff);
            state_in      = S_SECS_WAIT;
         end

         S_SECS_WAIT: begin
            if (div_res.done) begin
               secs_in   = sat_rate(div_res.quot);
               tvalid_in = 1'b1;
               state_in  = S_DONE;
            end
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_dl_in     = dl_ff;
               rsp_rate_in   = smooth_ff;
               rsp_pvalid_in = pvalid_ff;
               rsp_pct_in    = pct_ff;
               rsp_tvalid_in = tvalid_ff;
               rsp_secs_in   = secs_ff;
               rsp_play_in   = play_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State machine, control state and the result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prev_ff       <= '0;
         total_ff      <= '0;
         last_rcvd_ff  <= '0;
         last_time_ff  <= '0;
         wr_idx_ff     <= '0;
         fill_ff       <= '0;
         zero_ticks_ff <= '0;
         play_ff       <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         total_ff      <= total_in;
         last_rcvd_ff  <= last_rcvd_in;
         last_time_ff  <= last_time_in;
         wr_idx_ff     <= wr_idx_in;
         fill_ff       <= fill_in;
         zero_ticks_ff <= zero_ticks_in;
         play_ff       <= play_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Data path registers; these carry no reset.
   always_ff @(posedge clock) begin
      rcvd_ff       <= rcvd_in;
      now_ff        <= now_in;
      pos_ff        <= pos_in;
      diff_b_ff     <= diff_b_in;
      diff_t_ff     <= diff_t_in;
      dl_ff         <= dl_in;
      rate_t_ff     <= rate_t_in;
      pct_a_ff      <= pct_a_in;
      pct_b_ff      <= pct_b_in;
      pvalid_ff     <= pvalid_in;
      rate_ff       <= rate_in;
      rd_cnt_ff     <= rd_cnt_in;
      sum_ff        <= sum_in;
      smooth_ff     <= smooth_in;
      pct_ff        <= pct_in;
      tvalid_ff     <= tvalid_in;
      secs_ff       <= secs_in;
      rsp_dl_ff     <= rsp_dl_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
      rsp_pct_ff    <= rsp_pct_in;
      rsp_tvalid_ff <= rsp_tvalid_in;
      rsp_secs_ff   <= rsp_secs_in;
      rsp_play_ff   <= rsp_play_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_downloaded_bytes   = rsp_dl_ff;
   assign rsp_smoothed_rate      = rsp_rate_ff;
   assign rsp_progress_valid     = rsp_pvalid_ff;
   assign rsp_percent_hundredths = rsp_pct_ff;
   assign rsp_time_left_valid    = rsp_tvalid_ff;
   assign rsp_seconds_left       = rsp_secs_ff;
   assign rsp_play_ready         = rsp_play_ff;

`ifndef SYNTHESIS
   // The sequencer must never restart the divider mid-division.
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_res.busy)
      else $error("divider started while busy");

   // The fill count saturates at the ring depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(RING_DEPTH))
      else $error("fill count beyond ring depth");

   // A time estimate needs valid progress and a nonzero smoothed rate.
   a_time_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_time_left_valid ||
                     (rsp_progress_valid && (rsp_smoothed_rate != '0))))
      else $error("time left valid without progress or rate");

   // Percent done never exceeds one hundred percent.
   a_pct_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_percent_hundredths <= 14'd10000))
      else $error("percent above one hundred");
`endif

endmodule
